// File: sv/gamepad_input_change_events_defines.svh
// assertion macros for the gamepad change event block
`ifndef GAMEPAD_INPUT_CHANGE_EVENTS_DEFINES_SVH
`define GAMEPAD_INPUT_CHANGE_EVENTS_DEFINES_SVH

`ifndef SYNTH
`define GICE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gice assertion failed");
`define GICE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("gice forbidden condition seen");
`else
`define GICE_ASSERT(lbl, prop)
`define GICE_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: sv/gice_pkg.sv
package gice_pkg;

  localparam int DEF_NUM_PADS         = 4;
  localparam int DEF_CHANNELS_PER_PAD = 16;

  localparam int TYPE_W = 2;
  localparam int PAD_W  = 2;
  localparam int CHAN_W = 4;
  localparam int AXIS_W = 16;
  localparam int HAT_W  = 4;
  localparam int KIND_W = 3;
  localparam int DIR_W  = 2;
  localparam int THR_W  = 15;

  localparam logic [THR_W-1:0] THR_RESET = 15'h1fff;

  localparam logic [TYPE_W-1:0] REQ_AXIS   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_BUTTON = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_HAT    = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [DIR_W-1:0] DIR_PLUS    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_MINUS   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BUTTON     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AXIS_PLUS  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AXIS_MINUS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HAT_N      = 3'd3;

  localparam int EV_SLOTS = 4;
  localparam int SEL_W    = $clog2(EV_SLOTS);

  typedef struct packed {
    logic [HAT_W-1:0] hat;
    logic             button;
    logic [DIR_W-1:0] axis;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // events of one input, slot order is emit order
  typedef struct packed {
    logic [PAD_W-1:0]                  pad;
    logic [CHAN_W-1:0]                 chan;
    logic [EV_SLOTS-1:0]               valid;
    logic [EV_SLOTS-1:0]               pressed;
    logic [EV_SLOTS-1:0][KIND_W-1:0]   kind;
  } run_t;

endpackage

// File: sv/gice_in_if.sv
interface gice_in_if;
  import gice_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic [PAD_W-1:0]         pad_id;
  logic [CHAN_W-1:0]        channel_index;
  logic signed [AXIS_W-1:0] axis_value;
  logic                     button_pressed;
  logic [HAT_W-1:0]         hat_bits;

  modport source (
    output valid, req_type, pad_id, channel_index, axis_value, button_pressed, hat_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, pad_id, channel_index, axis_value, button_pressed, hat_bits,
    output ready
  );
endinterface

// File: sv/gice_out_if.sv
interface gice_out_if;
  import gice_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAD_W-1:0]  out_pad;
  logic [CHAN_W-1:0] out_channel;
  logic [KIND_W-1:0] control_kind;
  logic              is_pressed;
  logic              last_of_run;

  modport source (
    output valid, out_pad, out_channel, control_kind, is_pressed, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_pad, out_channel, control_kind, is_pressed, last_of_run,
    output ready
  );
endinterface

// File: sv/gice_ram.sv
module gice_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gice_emit.sv
module gice_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gice_pkg::run_t    run_i,
  output logic              free_o,
  gice_out_if.source        out_o
);
  import gice_pkg::*;

  run_t                run_q, run_d;
  logic [EV_SLOTS-1:0] pend_q, pend_d;
  logic [EV_SLOTS-1:0] low;
  logic [SEL_W-1:0]    sel;
  logic                single;
  logic                xfer;

  always_comb begin
    sel = '0;
    for (int i = EV_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign low    = pend_q & (~pend_q + EV_SLOTS'(1));
  assign single = (pend_q & (pend_q - EV_SLOTS'(1))) == '0;
  assign xfer   = out_o.valid && out_o.ready;
  assign free_o = (pend_q == '0) || (xfer && single);

  always_comb begin
    pend_d = pend_q;
    run_d  = run_q;
    if (xfer) begin
      pend_d = pend_q & ~low;
    end
    if (load_i) begin
      pend_d = run_i.valid;
      run_d  = run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  assign out_o.valid        = pend_q != '0;
  assign out_o.out_pad      = run_q.pad;
  assign out_o.out_channel  = run_q.chan;
  assign out_o.control_kind = run_q.kind[sel];
  assign out_o.is_pressed   = run_q.pressed[sel];
  assign out_o.last_of_run  = single;

endmodule

// File: sv/gamepad_input_change_events.sv
// channel   dir  handshake      payload
// in_i      in   valid/ready    req_type pad_id channel_index axis_value button_pressed hat_bits
// out_o     out  valid/ready    out_pad out_channel control_kind is_pressed last_of_run
// cfg       in   cfg_we_i       cfg_wdata_i (axis threshold)
//
// an input passes a state read stage and then a modify and write-back stage; a new
// input is taken every cycle while its predecessor has at most one event to send and
// the output takes it; events leave the emitter one per cycle while the output is ready,
// so an input with several events holds the next one until its last event goes out
// after reset a clearing pass writes NUM_PADS * CHANNELS_PER_PAD entries, one per cycle,
// and a pad clear sweeps CHANNELS_PER_PAD entries; no input is taken meanwhile
// an output stall only holds the pipeline once the emitter has events still pending
`include "gamepad_input_change_events_defines.svh"

module gamepad_input_change_events #(
  parameter int NUM_PADS         = gice_pkg::DEF_NUM_PADS,
  parameter int CHANNELS_PER_PAD = gice_pkg::DEF_CHANNELS_PER_PAD
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gice_pkg::THR_W-1:0] cfg_wdata_i,
  gice_in_if.sink                    in_i,
  gice_out_if.source                 out_o
);
  import gice_pkg::*;

  localparam int DEPTH = NUM_PADS * CHANNELS_PER_PAD;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  function automatic logic [KIND_W-1:0] dir_kind(input logic [DIR_W-1:0] dir);
    logic [KIND_W-1:0] k;
    unique case (dir)
      DIR_PLUS:  k = KIND_AXIS_PLUS;
      DIR_MINUS: k = KIND_AXIS_MINUS;
      default:   k = KIND_BUTTON;
    endcase
    return k;
  endfunction

  logic [THR_W-1:0] thr_q;

  logic              in_xfer;
  logic              pad_ok, chan_ok, in_keep;
  logic [AW-1:0]     in_addr;
  logic [DIR_W-1:0]  in_dir;
  logic signed [AXIS_W:0] v_ext, t_ext;

  logic              s1_valid_q, s1_valid_d;
  logic [TYPE_W-1:0] s1_type_q;
  logic [PAD_W-1:0]  s1_pad_q;
  logic [CHAN_W-1:0] s1_chan_q;
  logic [AW-1:0]     s1_addr_q;
  logic [DIR_W-1:0]  s1_dir_q;
  logic              s1_btn_q;
  logic [HAT_W-1:0]  s1_hat_q;

  logic [ENTRY_W-1:0] rd_data;
  entry_t             cur, nxt;
  run_t               run;
  logic               emit_free;
  logic               s1_adv, s1_we, clear_start;

  logic               fwd_valid_q;
  logic [AW-1:0]      fwd_addr_q;
  entry_t             fwd_data_q;

  logic               state_q, state_d;
  logic [AW-1:0]      swp_addr_q, swp_addr_d;
  logic [AW-1:0]      swp_last_q, swp_last_d;
  logic               swp_we;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // request decode and axis quantizer
  assign pad_ok  = 32'(in_i.pad_id) < NUM_PADS;
  assign chan_ok = 32'(in_i.channel_index) < CHANNELS_PER_PAD;
  assign in_keep = pad_ok && ((in_i.req_type == REQ_CLEAR) || chan_ok);
  assign in_addr = AW'(32'(in_i.pad_id) * CHANNELS_PER_PAD + 32'(in_i.channel_index));

  assign v_ext = {in_i.axis_value[AXIS_W-1], in_i.axis_value};
  assign t_ext = {2'b00, thr_q};

  always_comb begin
    if (v_ext > t_ext) begin
      in_dir = DIR_PLUS;
    end else if (v_ext < -t_ext) begin
      in_dir = DIR_MINUS;
    end else begin
      in_dir = DIR_NEUTRAL;
    end
  end

  assign in_i.ready = (state_q == ST_RUN) &&
                      (!s1_valid_q || (s1_adv && (s1_type_q != REQ_CLEAR)));
  assign in_xfer    = in_i.valid && in_i.ready;

  // read stage register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = in_keep;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_type_q <= in_i.req_type;
      s1_pad_q  <= in_i.pad_id;
      s1_chan_q <= in_i.channel_index;
      s1_addr_q <= in_addr;
      s1_dir_q  <= in_dir;
      s1_btn_q  <= in_i.button_pressed;
      s1_hat_q  <= in_i.hat_bits;
    end
  end

  // modify stage
  assign cur = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : entry_t'(rd_data);

  always_comb begin
    nxt         = cur;
    run.pad     = s1_pad_q;
    run.chan    = s1_chan_q;
    run.valid   = '0;
    run.pressed = '0;
    run.kind    = '0;
    unique case (s1_type_q)
      REQ_AXIS: begin
        nxt.axis = s1_dir_q;
        if (s1_dir_q != cur.axis) begin
          run.valid[0]   = cur.axis != DIR_NEUTRAL;
          run.kind[0]    = dir_kind(cur.axis);
          run.valid[1]   = s1_dir_q != DIR_NEUTRAL;
          run.kind[1]    = dir_kind(s1_dir_q);
          run.pressed[1] = 1'b1;
        end
      end
      REQ_BUTTON: begin
        nxt.button     = s1_btn_q;
        run.valid[0]   = s1_btn_q != cur.button;
        run.kind[0]    = KIND_BUTTON;
        run.pressed[0] = s1_btn_q;
      end
      REQ_HAT: begin
        nxt.hat = s1_hat_q;
        for (int i = 0; i < EV_SLOTS; i++) begin
          run.valid[i]   = s1_hat_q[i] ^ cur.hat[i];
          run.kind[i]    = KIND_HAT_N + KIND_W'(i);
          run.pressed[i] = s1_hat_q[i];
        end
      end
      REQ_CLEAR: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign s1_adv      = s1_valid_q && ((s1_type_q == REQ_CLEAR) || emit_free);
  assign s1_we       = s1_adv && (s1_type_q != REQ_CLEAR);
  assign clear_start = s1_adv && (s1_type_q == REQ_CLEAR);

  // last write, for a read that raced it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (swp_we) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= nxt;
    end
  end

  // clearing sweep
  assign swp_we = state_q == ST_SWEEP;

  always_comb begin
    state_d    = state_q;
    swp_addr_d = swp_addr_q;
    swp_last_d = swp_last_q;
    unique case (state_q)
      ST_RUN: begin
        if (clear_start) begin
          state_d    = ST_SWEEP;
          swp_addr_d = AW'(32'(s1_pad_q) * CHANNELS_PER_PAD);
          swp_last_d = AW'(32'(s1_pad_q) * CHANNELS_PER_PAD + CHANNELS_PER_PAD - 1);
        end
      end
      ST_SWEEP: begin
        if (swp_addr_q == swp_last_q) begin
          state_d = ST_RUN;
        end else begin
          swp_addr_d = swp_addr_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      swp_addr_q <= '0;
      swp_last_q <= AW'(DEPTH - 1);
    end else begin
      state_q    <= state_d;
      swp_addr_q <= swp_addr_d;
      swp_last_q <= swp_last_d;
    end
  end

  // state memory
  assign mem_we    = swp_we || s1_we;
  assign mem_waddr = swp_we ? swp_addr_q : s1_addr_q;
  assign mem_wdata = swp_we ? '0 : ENTRY_W'(nxt);

  gice_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_xfer),
    .raddr_i (in_addr),
    .rdata_o (rd_data)
  );

  gice_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_we),
    .run_i  (run),
    .free_o (emit_free),
    .out_o  (out_o)
  );

  `GICE_ASSERT(a_sweep_pipe_empty, state_q == ST_SWEEP |-> !s1_valid_q)
  `GICE_ASSERT_NEVER(a_single_writer, swp_we && s1_we)
  `GICE_ASSERT(a_no_take_in_sweep, in_xfer |-> state_q == ST_RUN)
  `GICE_ASSERT(a_fwd_track, s1_we |=> fwd_valid_q && fwd_addr_q == $past(s1_addr_q))

endmodule

// File: tb/gamepad_input_change_events_test.sv
`timescale 1ns / 1ps

module gamepad_input_change_events_test;
  import gice_pkg::*;

  localparam int CYCLE_LIMIT    = 100000;
  localparam int IDLE_WAIT      = 40;
  localparam int DRAIN_WAIT     = 40;
  localparam int LONG_HOLD      = 300;
  localparam int RAND_PER_PHASE = 12;
  localparam int NO_CFG         = -1;
  localparam int CHANS          = DEF_CHANNELS_PER_PAD;

  localparam logic [KIND_W-1:0] KIND_HAT_E = KIND_HAT_N + 3'd1;
  localparam logic [KIND_W-1:0] KIND_HAT_S = KIND_HAT_N + 3'd2;
  localparam logic [KIND_W-1:0] KIND_HAT_W = KIND_HAT_N + 3'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [PAD_W-1:0]  pad;
    logic [CHAN_W-1:0] chan;
    logic [AXIS_W-1:0] axis;
    logic              button;
    logic [HAT_W-1:0]  hat;
  } pad_req_t;

  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [CHAN_W-1:0] chan;
    logic [KIND_W-1:0] kind;
    logic              pressed;
    logic              last;
  } pad_event_t;

  typedef pad_event_t [EV_SLOTS-1:0] event_run_t;

  typedef struct {
    int                             thr_set;
    pad_req_t                       req;
    int                             n;
    logic [EV_SLOTS-1:0][3:0]       evs;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  gice_in_if  in_if();
  gice_out_if out_if();

  gamepad_input_change_events u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [THR_W-1:0] thr_model = THR_RESET;
  logic [DIR_W-1:0] axis_dir [DEF_NUM_PADS*CHANS] = '{default: DIR_NEUTRAL};
  logic             btn_lvl  [DEF_NUM_PADS*CHANS] = '{default: 1'b0};
  logic [HAT_W-1:0] hat_mask [DEF_NUM_PADS*CHANS] = '{default: '0};

  pad_event_t pending_events [$];
  dir_row_t   dir_rows [$];

  bit                       cur_typed;
  int                       cur_n;
  logic [EV_SLOTS-1:0][3:0] cur_evs;
  int  hold_kick;
  int  errors;
  int  items_sent;
  int  results_checked;
  int  thr_writes;
  int  cycles;

  function automatic logic [3:0] ev(logic [KIND_W-1:0] kind, logic pressed);
    return {pressed, kind};
  endfunction

  function automatic void add_row(int thr_set, logic [TYPE_W-1:0] t, int pad, int chan,
                                  logic [AXIS_W-1:0] axis, logic button, logic [HAT_W-1:0] hat,
                                  int n = -1, logic [3:0] e0 = '0, logic [3:0] e1 = '0,
                                  logic [3:0] e2 = '0, logic [3:0] e3 = '0);
    dir_row_t row;
    row.thr_set = thr_set;
    row.req = '{t, PAD_W'(pad), CHAN_W'(chan), axis, button, hat};
    row.n = n;
    row.evs[0] = e0;
    row.evs[1] = e1;
    row.evs[2] = e2;
    row.evs[3] = e3;
    dir_rows.push_back(row);
  endfunction

  function automatic pad_event_t mk_event(pad_req_t r, logic [KIND_W-1:0] kind, logic pressed);
    return '{r.pad, r.chan, kind, pressed, 1'b0};
  endfunction

  // computes the change events of one request and updates the stored pad state
  function automatic int predict_changes(pad_req_t r, output event_run_t run);
    int n;
    int slot;
    int v;
    int t;
    logic [DIR_W-1:0] now_dir;
    logic [DIR_W-1:0] was_dir;
    logic [HAT_W-1:0] was_hat;
    n = 0;
    run = '0;
    slot = int'(r.pad) * CHANS + int'(r.chan);
    case (r.req_type)
      REQ_CLEAR: begin
        for (int c = 0; c < CHANS; c++) begin
          axis_dir[int'(r.pad) * CHANS + c] = DIR_NEUTRAL;
          btn_lvl[int'(r.pad) * CHANS + c]  = 1'b0;
          hat_mask[int'(r.pad) * CHANS + c] = '0;
        end
      end
      REQ_AXIS: begin
        v = $signed(r.axis);
        t = int'(thr_model);
        now_dir = (v > t) ? DIR_PLUS : (v < -t) ? DIR_MINUS : DIR_NEUTRAL;
        was_dir = axis_dir[slot];
        if (now_dir != was_dir) begin
          axis_dir[slot] = now_dir;
          if (was_dir != DIR_NEUTRAL) begin
            run[n] = mk_event(r, (was_dir == DIR_PLUS) ? KIND_AXIS_PLUS : KIND_AXIS_MINUS, 1'b0);
            n++;
          end
          if (now_dir != DIR_NEUTRAL) begin
            run[n] = mk_event(r, (now_dir == DIR_PLUS) ? KIND_AXIS_PLUS : KIND_AXIS_MINUS, 1'b1);
            n++;
          end
        end
      end
      REQ_BUTTON: begin
        if (r.button != btn_lvl[slot]) begin
          btn_lvl[slot] = r.button;
          run[n] = mk_event(r, KIND_BUTTON, r.button);
          n++;
        end
      end
      default: begin
        was_hat = hat_mask[slot];
        hat_mask[slot] = r.hat;
        for (int b = 0; b < HAT_W; b++) begin
          if (was_hat[b] != r.hat[b]) begin
            run[n] = mk_event(r, KIND_HAT_N + KIND_W'(b), r.hat[b]);
            n++;
          end
        end
      end
    endcase
    if (n > 0) run[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic pad_req_t rand_req();
    pad_req_t r;
    int sel;
    int t;
    int v;
    sel = $urandom_range(0, 99);
    r.req_type = (sel < 35) ? REQ_AXIS : (sel < 60) ? REQ_BUTTON : (sel < 92) ? REQ_HAT : REQ_CLEAR;
    r.pad = PAD_W'($urandom_range(0, DEF_NUM_PADS - 1));
    r.chan = ($urandom_range(0, 3) != 0) ? CHAN_W'($urandom_range(0, 3))
                                         : CHAN_W'($urandom_range(0, CHANS - 1));
    t = int'(thr_model);
    case ($urandom_range(0, 3))
      0: v = $signed(AXIS_W'($urandom));
      1: begin
        case ($urandom_range(0, 3))
          0: v = t;
          1: v = t + 1;
          2: v = -t;
          default: v = -t - 1;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      2: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: v = 0;
    endcase
    r.axis = AXIS_W'(v);
    r.button = 1'($urandom_range(0, 1));
    r.hat = HAT_W'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic send_req(pad_req_t r, bit typed, int n, logic [EV_SLOTS-1:0][3:0] evs);
    @(negedge clk_i);
    cur_typed = typed;
    cur_n = n;
    cur_evs = evs;
    in_if.valid          <= 1'b1;
    in_if.req_type       <= r.req_type;
    in_if.pad_id         <= r.pad;
    in_if.channel_index  <= r.chan;
    in_if.axis_value     <= r.axis;
    in_if.button_pressed <= r.button;
    in_if.hat_bits       <= r.hat;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    pause(1);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_thr(int v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= THR_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_writes++;
  endtask

  task automatic report_field(string name, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk_i) begin
    pad_req_t   r;
    event_run_t run;
    pad_event_t got;
    pad_event_t want;
    int n;
    if (cfg_we_i === 1'b1) thr_model = cfg_wdata_i;
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      r = '{in_if.req_type, in_if.pad_id, in_if.channel_index, in_if.axis_value,
            in_if.button_pressed, in_if.hat_bits};
      n = predict_changes(r, run);
      if (cur_typed) begin
        n = cur_n;
        for (int i = 0; i < EV_SLOTS; i++) begin
          run[i] = mk_event(r, cur_evs[i][KIND_W-1:0], cur_evs[i][3]);
          run[i].last = (i == n - 1);
        end
      end
      for (int i = 0; i < n; i++) pending_events.push_back(run[i]);
      items_sent++;
    end
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.out_pad, out_if.out_channel, out_if.control_kind, out_if.is_pressed,
              out_if.last_of_run};
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (got.pad !== want.pad) report_field("out_pad", want.pad, got.pad);
        if (got.chan !== want.chan) report_field("out_channel", want.chan, got.chan);
        if (got.kind !== want.kind) report_field("control_kind", want.kind, got.kind);
        if (got.pressed !== want.pressed) report_field("is_pressed", want.pressed, got.pressed);
        if (got.last !== want.last) report_field("last_of_run", want.last, got.last);
      end
      results_checked++;
    end
  end

  // receiver with changing stall patterns and one long hold-off on request
  initial begin
    int cnt;
    int hold_left;
    logic [7:0] pat;
    cnt = 0;
    hold_left = 0;
    pat = 8'hff;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_kick != 0) begin
        hold_kick = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (cnt % 32 == 0) pat = ($urandom_range(0, 2) == 0) ? 8'hff : (8'($urandom) | 8'h01);
        out_if.ready <= pat[cnt % 8];
        cnt++;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int thr_plan [6];
    int sent;
    int burst;
    in_if.valid          = 1'b0;
    in_if.req_type       = REQ_AXIS;
    in_if.pad_id         = '0;
    in_if.channel_index  = '0;
    in_if.axis_value     = '0;
    in_if.button_pressed = 1'b0;
    in_if.hat_bits       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;

    // reset threshold
    add_row(NO_CFG, REQ_AXIS, 0, 0, 16'h7fff, 0, 0, 1, ev(KIND_AXIS_PLUS, 1));
    add_row(NO_CFG, REQ_AXIS, 0, 0, 16'h8000, 0, 0, 2, ev(KIND_AXIS_PLUS, 0),
            ev(KIND_AXIS_MINUS, 1));
    add_row(NO_CFG, REQ_AXIS, 0, 0, 16'sd8191, 0, 0, 1, ev(KIND_AXIS_MINUS, 0));
    add_row(NO_CFG, REQ_AXIS, 0, 0, -16'sd8191, 0, 0, 0);
    add_row(NO_CFG, REQ_AXIS, 0, 0, 16'sd8192, 0, 0, 1, ev(KIND_AXIS_PLUS, 1));
    add_row(NO_CFG, REQ_AXIS, 0, 0, -16'sd8192, 0, 0, 2, ev(KIND_AXIS_PLUS, 0),
            ev(KIND_AXIS_MINUS, 1));
    add_row(NO_CFG, REQ_BUTTON, 3, 15, 16'h8000, 1, 4'hf, 1, ev(KIND_BUTTON, 1));
    add_row(NO_CFG, REQ_BUTTON, 3, 15, 16'h0000, 1, 4'h0, 0);
    add_row(NO_CFG, REQ_BUTTON, 3, 15, 16'h7fff, 0, 4'hf, 1, ev(KIND_BUTTON, 0));
    add_row(NO_CFG, REQ_HAT, 1, 7, 16'h7fff, 1, 4'hf, 4, ev(KIND_HAT_N, 1), ev(KIND_HAT_E, 1),
            ev(KIND_HAT_S, 1), ev(KIND_HAT_W, 1));
    add_row(NO_CFG, REQ_HAT, 1, 7, 16'h0000, 0, 4'ha, 2, ev(KIND_HAT_N, 0), ev(KIND_HAT_S, 0));
    add_row(NO_CFG, REQ_HAT, 1, 7, 16'h8000, 0, 4'h5, 4, ev(KIND_HAT_N, 1), ev(KIND_HAT_E, 0),
            ev(KIND_HAT_S, 1), ev(KIND_HAT_W, 0));
    add_row(NO_CFG, REQ_HAT, 1, 7, 16'h0000, 1, 4'h5, 0);
    add_row(NO_CFG, REQ_AXIS, 2, 3, 16'sd100, 1, 4'hf, 0);
    add_row(NO_CFG, REQ_BUTTON, 2, 4, 16'h8000, 1, 4'hf, 1, ev(KIND_BUTTON, 1));
    // pad clear ignores the channel and the payload
    add_row(NO_CFG, REQ_CLEAR, 1, 9, 16'h8000, 1, 4'hf, 0);
    add_row(NO_CFG, REQ_HAT, 1, 7, 16'h0000, 0, 4'h5, 2, ev(KIND_HAT_N, 1), ev(KIND_HAT_S, 1));
    add_row(NO_CFG, REQ_CLEAR, 0, 0, 16'h0000, 0, 4'h0, 0);
    add_row(NO_CFG, REQ_AXIS, 0, 0, 16'h8000, 0, 0, 1, ev(KIND_AXIS_MINUS, 1));
    add_row(NO_CFG, REQ_HAT, 2, 0, 16'h1234, 1, 4'h3);
    // zero threshold
    add_row(0, REQ_AXIS, 2, 5, 16'sd1, 0, 0, 1, ev(KIND_AXIS_PLUS, 1));
    add_row(NO_CFG, REQ_AXIS, 2, 5, -16'sd1, 0, 0, 2, ev(KIND_AXIS_PLUS, 0),
            ev(KIND_AXIS_MINUS, 1));
    add_row(NO_CFG, REQ_AXIS, 2, 5, 16'sd0, 0, 0, 1, ev(KIND_AXIS_MINUS, 0));
    // full-scale threshold
    add_row(32767, REQ_AXIS, 2, 6, 16'h7fff, 0, 0, 0);
    add_row(NO_CFG, REQ_AXIS, 2, 6, 16'h8000, 0, 0, 1, ev(KIND_AXIS_MINUS, 1));
    add_row(NO_CFG, REQ_AXIS, 2, 6, -16'sd32767, 0, 0, 1, ev(KIND_AXIS_MINUS, 0));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].thr_set != NO_CFG) begin
        wait_idle();
        write_thr(dir_rows[i].thr_set);
      end
      send_req(dir_rows[i].req, dir_rows[i].n >= 0, dir_rows[i].n, dir_rows[i].evs);
      pause($urandom_range(0, 2));
    end

    thr_plan[0] = $urandom_range(0, 32767);
    thr_plan[1] = 0;
    thr_plan[2] = 32767;
    thr_plan[3] = $urandom_range(1, 200);
    thr_plan[4] = THR_RESET;
    thr_plan[5] = $urandom_range(16000, 32767);
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_thr(thr_plan[p]);
      // long output stall while the sender keeps offering
      if (p == 2) hold_kick = 1;
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        burst = $urandom_range(1, 8);
        if (burst > RAND_PER_PHASE - sent) burst = RAND_PER_PHASE - sent;
        repeat (burst) begin
          send_req(rand_req(), 1'b0, 0, '0);
          sent++;
        end
        if (p != 2 && p != 4) pause($urandom_range(0, 5));
      end
    end

    pause(1);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d request transfers, checked %0d event transfers, %0d threshold writes",
             items_sent, results_checked, thr_writes);
    $display("Covered axis swaps, hat diffs, pad clears, threshold extremes and a long stall");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/gice_pkg.sv
sv/gice_in_if.sv
sv/gice_out_if.sv
sv/gice_ram.sv
sv/gice_emit.sv
sv/gamepad_input_change_events.sv
tb/gamepad_input_change_events_test.sv
